// ===== rtl/cafe_pkg.sv =====
// shared types, constants and rounding helpers for the cubic anisotropy pipeline
`timescale 1ns / 1ps
package cafe_pkg;

   localparam int NSTG = 11;

   localparam int DIR_W  = 32;
   localparam int COEF_W = 33;
   localparam int MS_W   = 32;
   localparam int MSI_W  = 48;
   localparam int OUT_W  = 40;
   localparam int K_W    = 38;
   localparam int F_W    = 56;

   // 2/mu0 in Q.16 and mu0/2 in Q0.48
   localparam logic [36:0] TWO_OVER_MU0 = 37'd104303783505;
   localparam logic [27:0] HALF_MU0     = 28'd176855944;

   typedef logic signed [DIR_W-1:0] dir_type;
   typedef logic signed [OUT_W-1:0] out_type;
   typedef logic signed [95:0]      wide_type;

   localparam wide_type ONE_Q30 = wide_type'(1) <<< 30;

   // shift right by n, rounding half away from zero
   function automatic wide_type rnd_shr(input wide_type p, input int unsigned n);
      wide_type bias;
      bias = (wide_type'(1) <<< (n - 1)) - (p[95] ? wide_type'(1) : wide_type'(0));
      return (p + bias) >>> n;
   endfunction

   // clamp to a signed range of w bits
   function automatic wide_type sat_w(input wide_type v, input int unsigned w);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (w - 1)) - wide_type'(1);
      lo = -hi - wide_type'(1);
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // q2.30 product
   function automatic wide_type qm(input wide_type a, input wide_type b);
      return rnd_shr(a * b, 30);
   endfunction

endpackage

// ===== rtl/cafe_scale.sv =====
// four-stage pipeline that forms the energy scale k and the field multiplier f
`timescale 1ns / 1ps
module cafe_scale
   import cafe_pkg::*;
(
   input  logic                     clock,
   input  logic [3:0]               stage_en,
   input  logic                     coef_mode,
   input  logic signed [COEF_W-1:0] coefficient,
   input  logic [MS_W-1:0]          sat_mag,
   input  logic [MSI_W-1:0]         sat_mag_inverse,
   output logic signed [K_W-1:0]    k_ff,
   output logic signed [F_W-1:0]    f_ff
);

   logic [60:0]              ptl_ff, ptl_in, pth_ff, pth_in;
   logic signed [65:0]       hmp_ff, hmp_in;
   logic signed [COEF_W-1:0] coef_ff [0:2];
   logic [52:0]              t_ff, t_in;
   logic signed [57:0]       hm_ff, hm_in;
   logic signed [60:0]       fpl_ff, fpl_in, fph_ff, fph_in;
   logic signed [57:0]       kpl_ff, kpl_in, kph_ff, kph_in;
   logic signed [K_W-1:0]    k_in;
   logic signed [F_W-1:0]    f_in;

   always_comb begin
      wide_type tsum;
      wide_type hr;
      wide_type fr;
      wide_type kr;
      // 2/mu0 times 1/Ms, split over the two halves of 1/Ms
      ptl_in = 61'(wide_type'(TWO_OVER_MU0) * wide_type'(sat_mag_inverse[23:0]));
      pth_in = 61'(wide_type'(TWO_OVER_MU0) * wide_type'(sat_mag_inverse[47:24]));
      hmp_in = 66'(wide_type'(coefficient) * wide_type'({1'b0, sat_mag}));
      tsum = (wide_type'(pth_ff) <<< 24) + wide_type'(ptl_ff) + (wide_type'(1) <<< 31);
      t_in = 53'(tsum >>> 32);
      hr = rnd_shr(wide_type'(hmp_ff), 8);
      hm_in = 58'(hr);
      fpl_in = 61'(wide_type'(coef_ff[1]) * wide_type'({1'b0, t_ff[26:0]}));
      fph_in = 61'(wide_type'(coef_ff[1]) * wide_type'({1'b0, t_ff[52:27]}));
      kpl_in = 58'(wide_type'({1'b0, hm_ff[28:0]}) * wide_type'({1'b0, HALF_MU0}));
      kph_in = 58'(wide_type'($signed(hm_ff[57:29])) * wide_type'({1'b0, HALF_MU0}));
      fr = rnd_shr((wide_type'(fph_ff) <<< 27) + wide_type'(fpl_ff), 32);
      kr = rnd_shr((wide_type'(kph_ff) <<< 29) + wide_type'(kpl_ff), 48);
      if (coef_mode) begin
         f_in = F_W'(-wide_type'(coef_ff[2]));
         k_in = K_W'(kr);
      end else begin
         f_in = F_W'(-fr);
         k_in = K_W'(wide_type'(coef_ff[2]));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         ptl_ff     <= ptl_in;
         pth_ff     <= pth_in;
         hmp_ff     <= hmp_in;
         coef_ff[0] <= coefficient;
      end
      if (stage_en[1]) begin
         t_ff       <= t_in;
         hm_ff      <= hm_in;
         coef_ff[1] <= coef_ff[0];
      end
      if (stage_en[2]) begin
         fpl_ff     <= fpl_in;
         fph_ff     <= fph_in;
         kpl_ff     <= kpl_in;
         kph_ff     <= kph_in;
         coef_ff[2] <= coef_ff[1];
      end
      if (stage_en[3]) begin
         k_ff <= k_in;
         f_ff <= f_in;
      end
   end

endmodule

// ===== rtl/cubic_anisotropy_field_energy.sv =====
// Pipeline: an accepted req word passes NSTG register stages on its way to rsp_tvalid.
// Throughput: one cell per cycle with rsp_tready high; each stage has its own valid bit,
// so bubbles close up and a stalled rsp side fills the pipeline before req_tready drops.
// The longest stage is one multiplier of about 32 by 32 bits plus its rounding add.
// Reset clears all stage valid bits and sets coef_mode to 0 (K1 mode).
`timescale 1ns / 1ps
module cubic_anisotropy_field_energy
   import cafe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic         csr_wdata,    // coef_mode
   input  logic         req_tvalid,
   output logic         req_tready,
   // mag_x, mag_y, mag_z, axis_one_x..z, axis_two_x..z, coefficient, sat_mag,
   // sat_mag_inverse, 7 zero bits
   input  logic [407:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // energy_density, field_x, field_y, field_z, torque_x, torque_y, torque_z
   output logic [279:0] rsp_tdata
);

   logic            mode_ff;
   logic [NSTG-1:0] vld_ff;
   logic [NSTG:0]   en;

   dir_type                  mi [0:2];
   dir_type                  u1i [0:2];
   dir_type                  u2i [0:2];
   logic signed [COEF_W-1:0] coef_i;

   dir_type            m_ff [0:8][0:2];
   dir_type            u1_ff [0:4][0:2];
   dir_type            u2_ff [0:4][0:2];
   logic signed [33:0] qa_ff [0:2], qa_in [0:2], qb_ff [0:2], qb_in [0:2];
   dir_type            a1_ff [1:3], a2_ff [1:3];
   dir_type            a1_in, a2_in;
   logic signed [33:0] sq1_ff [2:3], sq2_ff [2:3];
   logic signed [33:0] sq1_in, sq2_in;
   dir_type            s_ff [3:4];
   dir_type            s_in, b1_ff, b1_in, b2_ff, b2_in;
   logic signed [K_W-1:0] k_sc, kc_ff [4:6];
   logic signed [F_W-1:0] f_sc, fc_ff [4:6];
   logic               zero_ff [4:7];
   logic               zero_in;
   logic signed [33:0] c1_ff, c1_in, c2_ff, c2_in;
   logic signed [35:0] q12_ff [4:5];
   logic signed [35:0] q12_in;
   dir_type            om_ff, om_in;
   logic signed [35:0] gu1_ff [0:2], gu1_in [0:2], gu2_ff [0:2], gu2_in [0:2];
   logic signed [33:0] gm_ff [0:2], gm_in [0:2];
   logic signed [33:0] qso_ff, qso_in;
   dir_type            g_ff [0:2], g_in [0:2];
   dir_type            poly_ff, poly_in;
   logic signed [60:0] hph_ff [0:2], hph_in [0:2], hpl_ff [0:2], hpl_in [0:2];
   logic signed [69:0] ep_ff, ep_in;
   out_type            h_ff [8:10][0:2];
   out_type            h_in [0:2];
   out_type            e_ff [8:10];
   out_type            e_in;
   logic signed [42:0] tp_ff [0:5], tp_in [0:5];
   out_type            tq_ff [0:2], tq_in [0:2];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         mi[j]  = dir_type'(req_tdata[32*j +: 32]);
         u1i[j] = dir_type'(req_tdata[96 + 32*j +: 32]);
         u2i[j] = dir_type'(req_tdata[192 + 32*j +: 32]);
      end
      coef_i = $signed(req_tdata[320:288]);
   end

   cafe_scale u_scale (
      .clock           (clock),
      .stage_en        (en[3:0]),
      .coef_mode       (mode_ff),
      .coefficient     (coef_i),
      .sat_mag         (req_tdata[352:321]),
      .sat_mag_inverse (req_tdata[400:353]),
      .k_ff            (k_sc),
      .f_ff            (f_sc)
   );

   // a stage takes a word when it is empty or its word moves on
   always_comb begin
      en[NSTG] = rsp_tready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = {tq_ff[2], tq_ff[1], tq_ff[0],
                        h_ff[10][2], h_ff[10][1], h_ff[10][0], e_ff[10]};

   always_comb begin
      wide_type hr;
      wide_type er;
      for (int j = 0; j < 3; j++) begin
         qa_in[j] = 34'(qm(mi[j], u1i[j]));
         qb_in[j] = 34'(qm(mi[j], u2i[j]));
      end
      a1_in = 32'(sat_w(wide_type'(qa_ff[0]) + wide_type'(qa_ff[1]) + wide_type'(qa_ff[2]), 32));
      a2_in = 32'(sat_w(wide_type'(qb_ff[0]) + wide_type'(qb_ff[1]) + wide_type'(qb_ff[2]), 32));
      sq1_in = 34'(qm(a1_ff[1], a1_ff[1]));
      sq2_in = 34'(qm(a2_ff[1], a2_ff[1]));
      s_in  = 32'(sat_w(wide_type'(sq1_ff[2]) + wide_type'(sq2_ff[2]), 32));
      b1_in = 32'(sat_w(ONE_Q30 - 2 * wide_type'(sq1_ff[2]) - wide_type'(sq2_ff[2]), 32));
      b2_in = 32'(sat_w(ONE_Q30 - wide_type'(sq1_ff[2]) - 2 * wide_type'(sq2_ff[2]), 32));
      c1_in  = 34'(qm(a1_ff[3], b1_ff));
      c2_in  = 34'(qm(a2_ff[3], b2_ff));
      q12_in = 36'(qm(sq1_ff[3], sq2_ff[3]));
      om_in  = 32'(sat_w(ONE_Q30 - wide_type'(s_ff[3]), 32));
      zero_in = (k_sc == '0) || (f_sc == '0);
      for (int j = 0; j < 3; j++) begin
         gu1_in[j] = 36'(qm(c1_ff, u1_ff[4][j]));
         gu2_in[j] = 36'(qm(c2_ff, u2_ff[4][j]));
         gm_in[j]  = 34'(qm(s_ff[4], m_ff[4][j]));
      end
      qso_in = 34'(qm(s_ff[4], om_ff));
      for (int j = 0; j < 3; j++) begin
         g_in[j] = 32'(sat_w(wide_type'(gu1_ff[j]) + wide_type'(gu2_ff[j])
                             + wide_type'(gm_ff[j]), 32));
      end
      poly_in = 32'(sat_w(wide_type'(q12_ff[5]) + wide_type'(qso_ff), 32));
      // f split into a signed high and an unsigned low part
      for (int j = 0; j < 3; j++) begin
         hph_in[j] = 61'(wide_type'($signed(fc_ff[6][55:28])) * wide_type'(g_ff[j]));
         hpl_in[j] = 61'(wide_type'({1'b0, fc_ff[6][27:0]}) * wide_type'(g_ff[j]));
      end
      ep_in = 70'(wide_type'(kc_ff[6]) * wide_type'(poly_ff));
      for (int j = 0; j < 3; j++) begin
         hr = sat_w(rnd_shr((wide_type'(hph_ff[j]) <<< 28) + wide_type'(hpl_ff[j]), 30), OUT_W);
         h_in[j] = zero_ff[7] ? '0 : OUT_W'(hr);
      end
      er = sat_w(rnd_shr(wide_type'(ep_ff), 30), OUT_W);
      e_in = zero_ff[7] ? '0 : OUT_W'(er);
      tp_in[0] = 43'(qm(m_ff[8][1], h_ff[8][2]));
      tp_in[1] = 43'(qm(m_ff[8][2], h_ff[8][1]));
      tp_in[2] = 43'(qm(m_ff[8][2], h_ff[8][0]));
      tp_in[3] = 43'(qm(m_ff[8][0], h_ff[8][2]));
      tp_in[4] = 43'(qm(m_ff[8][0], h_ff[8][1]));
      tp_in[5] = 43'(qm(m_ff[8][1], h_ff[8][0]));
      for (int j = 0; j < 3; j++) begin
         tq_in[j] = OUT_W'(sat_w(wide_type'(tp_ff[2*j]) - wide_type'(tp_ff[2*j+1]), OUT_W));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         vld_ff  <= '0;
      end else begin
         if (csr_wen) begin
            mode_ff <= csr_wdata;
         end
         if (en[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         m_ff[0]  <= mi;
         u1_ff[0] <= u1i;
         u2_ff[0] <= u2i;
         qa_ff    <= qa_in;
         qb_ff    <= qb_in;
      end
      for (int i = 1; i < 9; i++) begin
         if (en[i]) begin
            m_ff[i] <= m_ff[i-1];
         end
      end
      for (int i = 1; i < 5; i++) begin
         if (en[i]) begin
            u1_ff[i] <= u1_ff[i-1];
            u2_ff[i] <= u2_ff[i-1];
         end
      end
      if (en[1]) begin
         a1_ff[1] <= a1_in;
         a2_ff[1] <= a2_in;
      end
      if (en[2]) begin
         a1_ff[2]  <= a1_ff[1];
         a2_ff[2]  <= a2_ff[1];
         sq1_ff[2] <= sq1_in;
         sq2_ff[2] <= sq2_in;
      end
      if (en[3]) begin
         a1_ff[3]  <= a1_ff[2];
         a2_ff[3]  <= a2_ff[2];
         sq1_ff[3] <= sq1_ff[2];
         sq2_ff[3] <= sq2_ff[2];
         s_ff[3]   <= s_in;
         b1_ff     <= b1_in;
         b2_ff     <= b2_in;
      end
      if (en[4]) begin
         s_ff[4]    <= s_ff[3];
         c1_ff      <= c1_in;
         c2_ff      <= c2_in;
         q12_ff[4]  <= q12_in;
         om_ff      <= om_in;
         zero_ff[4] <= zero_in;
         kc_ff[4]   <= k_sc;
         fc_ff[4]   <= f_sc;
      end
      if (en[5]) begin
         q12_ff[5]  <= q12_ff[4];
         zero_ff[5] <= zero_ff[4];
         kc_ff[5]   <= kc_ff[4];
         fc_ff[5]   <= fc_ff[4];
         gu1_ff     <= gu1_in;
         gu2_ff     <= gu2_in;
         gm_ff      <= gm_in;
         qso_ff     <= qso_in;
      end
      if (en[6]) begin
         zero_ff[6] <= zero_ff[5];
         kc_ff[6]   <= kc_ff[5];
         fc_ff[6]   <= fc_ff[5];
         g_ff       <= g_in;
         poly_ff    <= poly_in;
      end
      if (en[7]) begin
         zero_ff[7] <= zero_ff[6];
         hph_ff     <= hph_in;
         hpl_ff     <= hpl_in;
         ep_ff      <= ep_in;
      end
      if (en[8]) begin
         h_ff[8] <= h_in;
         e_ff[8] <= e_in;
      end
      if (en[9]) begin
         h_ff[9] <= h_ff[8];
         e_ff[9] <= e_ff[8];
         tp_ff   <= tp_in;
      end
      if (en[10]) begin
         h_ff[10] <= h_ff[9];
         e_ff[10] <= e_ff[9];
         tq_ff    <= tq_in;
      end
   end

   // an empty first stage always takes a word
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0] |-> req_tready)
      else $error("req_tready low with empty first stage");

   // zero scale forces the field and energy to zero
   a_zero_field: assert property (@(posedge clock) disable iff (reset)
      vld_ff[7] && en[8] && zero_ff[7] |=>
         h_ff[8][0] == '0 && h_ff[8][1] == '0 && h_ff[8][2] == '0 && e_ff[8] == '0)
      else $error("nonzero field with zero scale");

   // a held first stage keeps its word
   a_hold_first: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !en[0] |=> vld_ff[0] && $stable(qa_ff[0]) && $stable(m_ff[0][0]))
      else $error("first stage word lost while stalled");

endmodule

// ===== dv/tb_top.sv =====
// scoreboard-checked stream test of the cubic anisotropy energy, field and torque pipeline
`timescale 1ns / 1ps
module tb_top;
   import cafe_pkg::*;

   typedef logic signed [127:0] acc_type;

   localparam acc_type LIM_DIR  = (acc_type'(1) <<< 31) - 1;
   localparam acc_type LIM_RES  = (acc_type'(1) <<< 39) - 1;
   localparam acc_type LIM_BIG  = (acc_type'(1) <<< 62) - 1;
   localparam acc_type UNIT_Q30 = acc_type'(1) <<< 30;
   localparam bit      MODE_K1  = 1'b0;
   localparam bit      MODE_HA  = 1'b1;

   class anisotropy_scoreboard;
      bit           coef_mode;
      logic [279:0] expected_q[$];
      int           errors;

      // magnitude product rounded half up, then sign restored and clamped
      function acc_type scaled_mul(acc_type a, acc_type b, int n, acc_type lim);
         logic [127:0] ua, ub, r;
         bit neg;
         neg = (a < 0) != (b < 0);
         ua = (a < 0) ? -a : a;
         ub = (b < 0) ? -b : b;
         r = (ua * ub + (128'd1 << (n - 1))) >> n;
         if (neg) begin
            if (r > 128'(lim + 1)) r = 128'(lim + 1);
            return -acc_type'(r);
         end
         if (r > 128'(lim)) r = 128'(lim);
         return acc_type'(r);
      endfunction

      function acc_type clamp(acc_type v, acc_type lim);
         if (v > lim) return lim;
         if (v < -lim - 1) return -lim - 1;
         return v;
      endfunction

      function acc_type dmul(acc_type a, acc_type b);
         return scaled_mul(a, b, 30, LIM_BIG);
      endfunction

      function logic [279:0] predict_cell(logic [407:0] d);
         acc_type m[3], u1[3], u2[3], g[3], h[3], res[7];
         acc_type coef, ms, msinv, k, f, t, hm;
         acc_type a1, a2, a1sq, a2sq, s, b1, b2, c1, c2, poly;
         logic [279:0] packed_res;
         for (int i = 0; i < 3; i++) begin
            m[i]  = acc_type'($signed(d[32*i +: 32]));
            u1[i] = acc_type'($signed(d[32*(3+i) +: 32]));
            u2[i] = acc_type'($signed(d[32*(6+i) +: 32]));
         end
         coef  = acc_type'($signed(d[320:288]));
         ms    = acc_type'(d[352:321]);
         msinv = acc_type'(d[400:353]);
         if (coef_mode == MODE_K1) begin
            t = scaled_mul(acc_type'(TWO_OVER_MU0), msinv, 32, LIM_BIG);
            k = coef;
            f = -scaled_mul(coef, t, 32, LIM_BIG);
         end else begin
            hm = scaled_mul(coef, ms, 8, LIM_BIG);
            f = -coef;
            k = scaled_mul(hm, acc_type'(HALF_MU0), 48, LIM_BIG);
         end
         for (int i = 0; i < 7; i++) res[i] = 0;
         if (k != 0 && f != 0) begin
            a1 = clamp(dmul(m[0], u1[0]) + dmul(m[1], u1[1]) + dmul(m[2], u1[2]), LIM_DIR);
            a2 = clamp(dmul(m[0], u2[0]) + dmul(m[1], u2[1]) + dmul(m[2], u2[2]), LIM_DIR);
            a1sq = dmul(a1, a1);
            a2sq = dmul(a2, a2);
            s  = clamp(a1sq + a2sq, LIM_DIR);
            b1 = clamp(UNIT_Q30 - 2 * a1sq - a2sq, LIM_DIR);
            b2 = clamp(UNIT_Q30 - a1sq - 2 * a2sq, LIM_DIR);
            c1 = dmul(a1, b1);
            c2 = dmul(a2, b2);
            for (int i = 0; i < 3; i++)
               g[i] = clamp(dmul(c1, u1[i]) + dmul(c2, u2[i]) + dmul(s, m[i]), LIM_DIR);
            poly = clamp(dmul(a1sq, a2sq) + dmul(s, clamp(UNIT_Q30 - s, LIM_DIR)), LIM_DIR);
            res[0] = scaled_mul(k, poly, 30, LIM_RES);
            for (int i = 0; i < 3; i++) begin
               h[i] = scaled_mul(f, g[i], 30, LIM_RES);
               res[1+i] = h[i];
            end
            // torque from the already saturated field
            for (int i = 0; i < 3; i++)
               res[4+i] = clamp(scaled_mul(m[(i+1)%3], h[(i+2)%3], 30, LIM_BIG)
                              - scaled_mul(m[(i+2)%3], h[(i+1)%3], 30, LIM_BIG), LIM_RES);
         end
         for (int i = 0; i < 7; i++) packed_res[40*i +: 40] = res[i][39:0];
         return packed_res;
      endfunction

      function void note_cell(logic [407:0] d);
         expected_q.push_back(predict_cell(d));
      endfunction

      function void check_result(logic [279:0] r);
         logic [279:0] e;
         string names[7];
         names = '{"energy_density", "field_x", "field_y", "field_z",
                   "torque_x", "torque_y", "torque_z"};
         if (expected_q.size() == 0) begin
            $error("unexpected result word %h", r);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         for (int i = 0; i < 7; i++)
            if (r[40*i +: 40] !== e[40*i +: 40]) begin
               $error("%s expected %0d got %0d", names[i],
                      $signed(e[40*i +: 40]), $signed(r[40*i +: 40]));
               errors++;
            end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         csr_wen;
   logic         csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [407:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [279:0] rsp_tdata;

   anisotropy_scoreboard sb;
   int burst_left;
   int unsigned cyc = 0;

   cubic_anisotropy_field_energy u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

   // receiver: always ready, fixed pattern, or random, taken in turn by windows of cyc
   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) sb.check_result(rsp_tdata);
      cyc <= cyc + 1;
      case ((cyc / 256) % 3)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= (cyc % 7) > 2;
         end
         default: begin
            rsp_tready <= $urandom_range(0, 3) != 0;
         end
      endcase
   end

   function automatic logic [407:0] pack_cell(logic [31:0] m[3], logic [31:0] u1[3],
                                              logic [31:0] u2[3], logic [32:0] coef,
                                              logic [31:0] ms, logic [47:0] msinv);
      logic [407:0] d;
      d = '0;
      for (int i = 0; i < 3; i++) begin
         d[32*i +: 32]     = m[i];
         d[32*(3+i) +: 32] = u1[i];
         d[32*(6+i) +: 32] = u2[i];
      end
      d[320:288] = coef;
      d[352:321] = ms;
      d[400:353] = msinv;
      return d;
   endfunction

   function automatic logic [407:0] random_cell();
      logic [31:0] m[3], u1[3], u2[3];
      logic [32:0] coef;
      logic [31:0] ms;
      logic [47:0] msinv;
      logic [407:0] d;
      int p, q;
      if ($urandom_range(0, 9) == 0) begin
         // raw noise on every bit below bit 401; the pad bits stay zero
         d = '0;
         for (int i = 0; i < 12; i++) d[32*i +: 32] = $urandom;
         d[400:384] = 17'($urandom);
         return d;
      end
      p = $urandom_range(0, 2);
      q = (p + $urandom_range(1, 2)) % 3;
      for (int i = 0; i < 3; i++) begin
         m[i]  = 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000);
         u1[i] = '0;
         u2[i] = '0;
      end
      u1[p] = $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
      u2[q] = $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
      if ($urandom_range(0, 4) == 0) m[$urandom_range(0, 2)] = $urandom;
      coef = 33'($urandom_range(1, 1 << 20)) << $urandom_range(0, 12);
      if ($urandom_range(0, 1)) coef = -coef;
      ms = $urandom_range(257, 1 << 28);
      msinv = 48'(64'h0100_0000_0000_0000 / ms);
      return pack_cell(m, u1, u2, coef, ms, msinv);
   endfunction

   task automatic send_cell(logic [407:0] d);
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_cell(d);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 12);
      end
   endtask

   task automatic drain_and_set_mode(bit mode);
      if (req_tvalid) req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (NSTG + 4) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.coef_mode = mode;
      @(posedge clock);
   endtask

   task automatic send_directed();
      logic [31:0] m[3], u1[3], u2[3], z[3];
      m  = '{32'h4000_0000, 32'h0, 32'h0};
      u1 = '{32'h4000_0000, 32'h0, 32'h0};
      u2 = '{32'h0, 32'h4000_0000, 32'h0};
      z  = '{32'h0, 32'h0, 32'h0};
      send_cell('0);
      // zero coefficient, zero ms, zero reciprocal
      send_cell(pack_cell(m, u1, u2, 33'd0, 32'd25600, 48'd10995116277760));
      send_cell(pack_cell(m, u1, u2, 33'd12800, 32'd0, 48'd10995116277760));
      send_cell(pack_cell(m, u1, u2, 33'd12800, 32'd25600, 48'd0));
      // typical cell, m along an axis and between axes
      send_cell(pack_cell(m, u1, u2, 33'd12800, 32'd25600, 48'd10995116277760));
      send_cell(pack_cell('{32'h2D41_3CCD, 32'h2D41_3CCD, 32'h0}, u1, u2,
                          -33'sd12800, 32'd25600, 48'd10995116277760));
      send_cell(pack_cell('{32'h24F3_4E8B, 32'h24F3_4E8B, 32'h24F3_4E8B}, u1, u2,
                          33'd5000000, 32'd300000, 48'd240185678));
      // field extremes
      send_cell(pack_cell(m, u1, u2, 33'h0_FFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
      send_cell(pack_cell(m, u1, u2, 33'h1_0000_0000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
      send_cell(pack_cell('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                          '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
                          '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000},
                          33'h1_0000_0000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
      send_cell(pack_cell('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, u1, u2,
                          33'h1_FFFF_FFFF, 32'd1, 48'd1));
      // non-orthogonal, non-unit and zero vectors
      send_cell(pack_cell(m, u1, u1, 33'd256, 32'd256, 48'hFFFF_FFFF_FFFF));
      send_cell(pack_cell(z, u1, u2, 33'd256, 32'd256, 48'hFFFF_FFFF_FFFF));
      send_cell(pack_cell(m, z, z, 33'd256, 32'd256, 48'hFFFF_FFFF_FFFF));
   endtask

   initial begin
      reset      = 1'b1;
      csr_wen    = 1'b0;
      csr_wdata  = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      sb = new();
      burst_left = 5;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drain_and_set_mode(MODE_K1);
      send_directed();
      drain_and_set_mode(MODE_HA);
      send_directed();
      for (int ph = 0; ph < 4; ph++) begin
         drain_and_set_mode(ph % 2 ? MODE_HA : MODE_K1);
         repeat (200) send_cell(random_cell());
      end
      if (req_tvalid) req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (NSTG + 4) @(posedge clock);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
